@@ sv/tcw_pkg.sv @@
package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
  localparam int unsigned COPY_COUNT = (ROWS - 1) * COLUMNS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);

  // Field widths
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CELL_W = 16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_PRINT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_ROW = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_COL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

  // Control characters
  localparam logic [7:0] CH_NONE    = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ADVANCE = 8'h0D;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        char_code;
    logic [7:0]        color;
    logic [7:0]        position_value;
    logic [10:0]       cell_address;
  } tcw_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_column;
    logic [7:0]       cell_char;
    logic [7:0]       cell_color;
  } tcw_out_t;

  // Result of one cursor step
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             scroll;
  } tcw_step_t;

endpackage

@@ sv/tcw_cursor_step.sv @@
module tcw_cursor_step (
  input  logic [tcw_pkg::ROW_W-1:0] row_i,
  input  logic [tcw_pkg::COL_W-1:0] col_i,
  input  logic                      newline_i,
  output tcw_pkg::tcw_step_t        step_o
);

  logic last_col;
  logic bottom_row;
  logic wrap;

  assign last_col   = (col_i == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
  assign bottom_row = (row_i == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign wrap       = newline_i || last_col;

  // Advance one column, or move to the next row; past the bottom row, scroll
  always_comb begin
    step_o.scroll = wrap && bottom_row;
    if (wrap) begin
      step_o.col = '0;
      step_o.row = bottom_row ? row_i : row_i + tcw_pkg::ROW_W'(1);
    end else begin
      step_o.col = col_i + tcw_pkg::COL_W'(1);
      step_o.row = row_i;
    end
  end

endmodule

@@ sv/text_console_cell_writer_core.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_item_i   (tcw_pkg::tcw_in_t)
// out      output     out_valid_o / out_stall_i out_item_o  (tcw_pkg::tcw_out_t)
//
// One item at a time: the input stalls until the current item's result has been registered.
// Each scroll and each clear adds a walk of the whole cell store, CELL_COUNT cells,
// through its single write port.
// After reset a clearing pass over the whole cell store runs before the first item.
// A waiting result does not block input; an item ends once the output register is free.
module text_console_cell_writer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcw_pkg::tcw_in_t    in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcw_pkg::tcw_out_t   out_item_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADVANCE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RDWAIT,
    ST_DONE
  } state_e;

  localparam int unsigned AW = tcw_pkg::ADDR_W;

  state_e                      state_q;
  state_e                      ret_q;
  tcw_pkg::tcw_in_t            item_q;
  logic [tcw_pkg::ROW_W-1:0]   row_q;
  logic [tcw_pkg::COL_W-1:0]   col_q;
  logic                        newline_q;
  logic [2:0]                  steps_q;
  logic                        clear_q;
  logic [AW-1:0]               cnt_q;
  logic                        wr_pend_q;
  logic [AW-1:0]               wr_addr_q;
  logic                        wr_zero_q;
  logic [tcw_pkg::CELL_W-1:0]  rd_data_q;
  logic [tcw_pkg::CELL_W-1:0]  cell_q;
  logic                        out_valid_q;
  tcw_pkg::tcw_out_t           out_q;

  logic [tcw_pkg::CELL_W-1:0]  mem [tcw_pkg::CELL_COUNT];

  tcw_pkg::tcw_step_t          step;
  logic                        plain_char;
  logic                        addr_ok;
  logic [AW-1:0]               cur_addr;
  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [tcw_pkg::CELL_W-1:0]  mem_wd;
  logic [AW-1:0]               mem_ra;

  tcw_cursor_step u_step (
    .row_i     (row_q),
    .col_i     (col_q),
    .newline_i (newline_q),
    .step_o    (step)
  );

  assign plain_char = (item_q.char_code != tcw_pkg::CH_NONE)
                   && (item_q.char_code != tcw_pkg::CH_TAB)
                   && (item_q.char_code != tcw_pkg::CH_NEWLINE)
                   && (item_q.char_code != tcw_pkg::CH_ADVANCE);
  assign addr_ok    = (item_q.cell_address < AW'(tcw_pkg::CELL_COUNT));
  assign cur_addr   = AW'(row_q) * AW'(tcw_pkg::COLUMNS) + AW'(col_q);

  // Pick the store's write and read ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr_q;
    mem_wd = wr_zero_q ? '0 : rd_data_q;
    if (wr_pend_q) begin
      mem_we = 1'b1;
    end else if (state_q == ST_EXEC && item_q.kind == tcw_pkg::KIND_PRINT && plain_char) begin
      mem_we = 1'b1;
      mem_wa = cur_addr;
      mem_wd = {item_q.color, item_q.char_code};
    end
    if (state_q == ST_SWEEP) begin
      mem_ra = (cnt_q < AW'(tcw_pkg::COPY_COUNT)) ? cnt_q + AW'(tcw_pkg::COLUMNS) : '0;
    end else begin
      mem_ra = addr_ok ? item_q.cell_address : '0;
    end
  end

  // Cell store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[mem_ra];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      ret_q       <= ST_IDLE;
      clear_q     <= 1'b1;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
      wr_zero_q   <= 1'b1;
      row_q       <= '0;
      col_q       <= '0;
      newline_q   <= 1'b0;
      steps_q     <= '0;
      item_q      <= '0;
      cell_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Raise the output when a result is ready, drop it once taken
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // The write scheduled in a sweep cycle lands in the cycle after it
      wr_pend_q <= (state_q == ST_SWEEP);
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cell_q    <= '0;
          newline_q <= (item_q.kind == tcw_pkg::KIND_PRINT)
                    && (item_q.char_code == tcw_pkg::CH_NEWLINE);
          case (item_q.kind)
            tcw_pkg::KIND_PRINT: begin
              if (item_q.char_code == tcw_pkg::CH_NONE) begin
                state_q <= ST_DONE;
              end else begin
                steps_q <= (item_q.char_code == tcw_pkg::CH_TAB) ? 3'd4 : 3'd1;
                state_q <= ST_ADVANCE;
              end
            end
            tcw_pkg::KIND_SET_ROW: begin
              row_q <= (item_q.position_value > 8'(tcw_pkg::ROWS - 1))
                     ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                     : tcw_pkg::ROW_W'(item_q.position_value);
              state_q <= ST_DONE;
            end
            tcw_pkg::KIND_SET_COL: begin
              col_q <= (item_q.position_value > 8'(tcw_pkg::COLUMNS - 1))
                     ? tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)
                     : tcw_pkg::COL_W'(item_q.position_value);
              state_q <= ST_DONE;
            end
            tcw_pkg::KIND_CLEAR: begin
              clear_q <= 1'b1;
              cnt_q   <= '0;
              ret_q   <= ST_DONE;
              state_q <= ST_SWEEP;
            end
            tcw_pkg::KIND_READ: begin
              state_q <= ST_RDWAIT;
            end
            default: begin
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_ADVANCE: begin
          // Take one cursor step; scroll when it runs off the bottom row
          row_q   <= step.row;
          col_q   <= step.col;
          steps_q <= steps_q - 3'd1;
          if (step.scroll) begin
            clear_q <= 1'b0;
            cnt_q   <= '0;
            ret_q   <= (steps_q == 3'd1) ? ST_DONE : ST_ADVANCE;
            state_q <= ST_SWEEP;
          end else if (steps_q == 3'd1) begin
            state_q <= ST_DONE;
          end
        end
        ST_SWEEP: begin
          // Schedule the write for this cell; its data arrives next cycle
          wr_addr_q <= cnt_q;
          wr_zero_q <= clear_q || (cnt_q >= AW'(tcw_pkg::COPY_COUNT));
          cnt_q     <= cnt_q + AW'(1);
          if (cnt_q == AW'(tcw_pkg::CELL_COUNT - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ret_q;
        end
        ST_RDWAIT: begin
          cell_q  <= addr_ok ? rd_data_q : '0;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.cursor_row    <= row_q;
            out_q.cursor_column <= col_q;
            out_q.cell_char     <= cell_q[7:0];
            out_q.cell_color    <= cell_q[15:8];
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1750;
  localparam int unsigned SCROLL_BUDGET = 40;
  localparam int unsigned CLEAR_BUDGET  = 12;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned DRAIN_CYCLES  = 50;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned ADDR_TOP      = 2047;
  localparam int unsigned KIND_TOP      = (1 << KIND_W) - 1;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  // Shadow console: cell store, cursor and the status items still owed
  class console_shadow;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    tcw_out_t          pending_status [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       scrolls;
    int unsigned       clears;
    int unsigned       reads_hit;

    function void reset_state();
      foreach (cells[i]) cells[i] = '0;
      row = '0;
      col = '0;
      pending_status.delete();
      errors = 0;
      checked = 0;
      scrolls = 0;
      clears = 0;
      reads_hit = 0;
    endfunction

    // Move every row up by one and blank the bottom row
    function void scroll_store();
      int i;
      for (i = 0; i < COPY_COUNT; i++) cells[i] = cells[i + COLUMNS];
      for (i = COPY_COUNT; i < CELL_COUNT; i++) cells[i] = '0;
      scrolls++;
    endfunction

    function void step_row();
      if (row == LAST_ROW) begin
        col = '0;
        scroll_store();
      end else begin
        row = row + 1'b1;
      end
    endfunction

    function void step_column();
      if (col == LAST_COL) begin
        step_row();
        col = '0;
      end else begin
        col = col + 1'b1;
      end
    endfunction

    function void print_char(logic [7:0] ch, logic [7:0] colour);
      int idx;
      case (ch)
        CH_NONE: ;
        CH_NEWLINE: begin
          col = '0;
          step_row();
        end
        CH_ADVANCE: step_column();
        CH_TAB: repeat (4) step_column();
        default: begin
          idx = int'(row) * COLUMNS + int'(col);
          cells[idx] = {colour, ch};
          step_column();
        end
      endcase
    endfunction

    // True if a print item would push the cursor past the bottom row
    function bit would_scroll(tcw_in_t it);
      int steps;
      if (it.kind != KIND_PRINT || row != LAST_ROW) return 1'b0;
      case (it.char_code)
        CH_NONE:    steps = 0;
        CH_NEWLINE: return 1'b1;
        CH_TAB:     steps = 4;
        default:    steps = 1;
      endcase
      return int'(col) + steps >= COLUMNS;
    endfunction

    // Apply one accepted item and queue the status it must produce
    function void take_item(tcw_in_t it);
      tcw_out_t status;
      int addr;
      status = '0;
      case (it.kind)
        KIND_PRINT: print_char(it.char_code, it.color);
        KIND_SET_ROW: begin
          if (int'(it.position_value) > ROWS - 1) row = LAST_ROW;
          else row = ROW_W'(it.position_value);
        end
        KIND_SET_COL: begin
          if (int'(it.position_value) > COLUMNS - 1) col = LAST_COL;
          else col = COL_W'(it.position_value);
        end
        KIND_CLEAR: begin
          foreach (cells[i]) cells[i] = '0;
          clears++;
        end
        KIND_READ: begin
          addr = int'(it.cell_address);
          if (addr < CELL_COUNT) begin
            status.cell_char  = cells[addr][7:0];
            status.cell_color = cells[addr][15:8];
            if (cells[addr] != '0) reads_hit++;
          end
        end
        default: ;
      endcase
      status.cursor_row    = row;
      status.cursor_column = col;
      pending_status.push_back(status);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    // Compare one delivered status item with the oldest one owed
    function void check_status(tcw_out_t got);
      tcw_out_t want;
      if (pending_status.size() == 0) begin
        note_error($sformatf("status item with none owed: row %0d col %0d char %02h colour %02h",
                             got.cursor_row, got.cursor_column, got.cell_char, got.cell_color));
        return;
      end
      want = pending_status.pop_front();
      checked++;
      if (got.cursor_row != want.cursor_row || got.cursor_column != want.cursor_column ||
          got.cell_char != want.cell_char || got.cell_color != want.cell_color)
        note_error($sformatf({"status item %0d: expected row %0d col %0d char %02h ",
                              "colour %02h, got row %0d col %0d char %02h colour %02h"},
                             checked, want.cursor_row, want.cursor_column, want.cell_char,
                             want.cell_color, got.cursor_row, got.cursor_column,
                             got.cell_char, got.cell_color));
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  tcw_in_t  in_item_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tcw_out_t out_item_o;

  console_shadow shadow;
  int unsigned   sent;
  int unsigned   burst_left;
  int unsigned   cycles;

  text_console_cell_writer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Count cycles, check delivered items and stall the output on a shifting pattern
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d status items still owed",
               cycles, shadow.pending_status.size());
      $display("Mismatches found");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && !out_stall_i) shadow.check_status(out_item_o);
      case ((cycles / 256) % 4)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ((cycles % 9) < 4);
      endcase
    end
  end

  function automatic tcw_in_t make_item(logic [KIND_W-1:0] kind, logic [7:0] ch,
                                        logic [7:0] colour, logic [7:0] pos,
                                        logic [10:0] addr);
    tcw_in_t it;
    it.kind           = kind;
    it.char_code      = ch;
    it.color          = colour;
    it.position_value = pos;
    it.cell_address   = addr;
    return it;
  endfunction

  // Random content in every field, with the given kind
  function automatic tcw_in_t noise_item(logic [KIND_W-1:0] kind);
    return make_item(kind, 8'($urandom), 8'($urandom), 8'($urandom),
                     11'($urandom_range(0, ADDR_TOP)));
  endfunction

  // Hold valid and the item until the block takes it
  task automatic send_item(input tcw_in_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    shadow.take_item(it);
    sent++;
  endtask

  task automatic pause(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Send within the scroll and clear budgets, then gap between bursts
  task automatic issue(input tcw_in_t it);
    if (it.kind == KIND_CLEAR && shadow.clears >= CLEAR_BUDGET) it.kind = KIND_READ;
    if (shadow.would_scroll(it) && shadow.scrolls >= SCROLL_BUDGET) begin
      it.kind           = KIND_SET_ROW;
      it.position_value = 8'($urandom_range(0, ROWS - 2));
    end
    send_item(it);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      pause($urandom_range(1, 9));
    end
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return CH_NONE;
        1:       return CH_TAB;
        2:       return CH_NEWLINE;
        default: return CH_ADVANCE;
      endcase
    end
    if (r == 1) return 8'($urandom);
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Place the cursor, print a string, then read part of it back
  task automatic print_run();
    tcw_in_t it;
    int      start;
    int      n;
    int      addr;
    it = noise_item(KIND_SET_ROW);
    if ($urandom_range(0, 9) == 0) it.position_value = 8'(ROWS - 1);
    else it.position_value = 8'($urandom_range(0, ROWS - 2));
    issue(it);
    it = noise_item(KIND_SET_COL);
    if ($urandom_range(0, 9) != 0) it.position_value = 8'($urandom_range(0, COLUMNS - 1));
    issue(it);
    start = int'(shadow.row) * COLUMNS + int'(shadow.col);
    n = $urandom_range(1, 24);
    repeat (n) begin
      it = noise_item(KIND_PRINT);
      it.char_code = pick_char();
      issue(it);
    end
    repeat ($urandom_range(1, 4)) begin
      addr = start + $urandom_range(0, n + 2);
      if (addr > ADDR_TOP) addr = ADDR_TOP;
      it = noise_item(KIND_READ);
      it.cell_address = 11'(addr);
      issue(it);
    end
  endtask

  initial begin
    tcw_in_t     it;
    int unsigned sel;
    shadow = new();
    shadow.reset_state();
    sent       = 0;
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: controls, saturation, wrap and scroll, edge reads, unknown kinds
    send_item(make_item(KIND_READ, 8'h00, 8'h00, 8'h00, 11'd0));
    send_item(make_item(KIND_PRINT, 8'h41, 8'hFF, 8'h00, 11'd0));
    send_item(make_item(KIND_PRINT, CH_NONE, 8'hFF, 8'hFF, 11'h7FF));
    send_item(make_item(KIND_PRINT, CH_ADVANCE, 8'h12, 8'h00, 11'd0));
    send_item(make_item(KIND_PRINT, CH_TAB, 8'h34, 8'h00, 11'd0));
    send_item(make_item(KIND_PRINT, CH_NEWLINE, 8'h56, 8'h00, 11'd0));
    send_item(make_item(KIND_READ, 8'h00, 8'h00, 8'h00, 11'd0));
    send_item(make_item(KIND_SET_ROW, 8'h00, 8'h00, 8'hFF, 11'd0));
    send_item(make_item(KIND_SET_COL, 8'h00, 8'h00, 8'hFF, 11'd0));
    send_item(make_item(KIND_PRINT, 8'hFF, 8'h00, 8'h00, 11'd0));
    send_item(make_item(KIND_READ, 8'h00, 8'h00, 8'h00, 11'(COPY_COUNT - 1)));
    send_item(make_item(KIND_READ, 8'h00, 8'h00, 8'h00, 11'h7FF));
    send_item(make_item(KIND_READ, 8'h00, 8'h00, 8'h00, 11'(CELL_COUNT)));
    send_item(make_item(KIND_SET_COL, 8'h00, 8'h00, 8'(COLUMNS - 2), 11'd0));
    send_item(make_item(KIND_PRINT, CH_TAB, 8'h00, 8'h00, 11'd0));
    send_item(make_item(KIND_READ, 8'hFF, 8'hFF, 8'hFF, 11'(COPY_COUNT - COLUMNS - 1)));
    send_item(make_item(KIND_TOP[KIND_W-1:0], 8'hFF, 8'hFF, 8'hFF, 11'h7FF));
    send_item(make_item(KIND_W'(int'(KIND_READ) + 1), 8'h5A, 8'hA5, 8'h3C, 11'h2AA));
    send_item(make_item(KIND_SET_ROW, 8'h00, 8'h00, 8'h00, 11'd0));
    send_item(make_item(KIND_SET_COL, 8'h00, 8'h00, 8'h00, 11'd0));
    send_item(make_item(KIND_PRINT, 8'h80, 8'h5A, 8'h00, 11'd0));
    send_item(make_item(KIND_CLEAR, 8'hFF, 8'hFF, 8'hFF, 11'h7FF));
    send_item(make_item(KIND_READ, 8'h00, 8'h00, 8'h00, 11'd0));
    send_item(make_item(KIND_SET_ROW, 8'h00, 8'h00, 8'(ROWS - 1), 11'd0));
    send_item(make_item(KIND_PRINT, CH_NEWLINE, 8'h00, 8'h00, 11'd0));
    pause(3);

    // Random: mostly placed strings with readback, plus reads, sets, clears and noise
    while (sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        print_run();
      end else if (sel < 70) begin
        repeat ($urandom_range(1, 6)) begin
          it = noise_item(KIND_READ);
          if ($urandom_range(0, 4) != 0)
            it.cell_address = 11'($urandom_range(0, CELL_COUNT - 1));
          else
            it.cell_address = 11'($urandom_range(CELL_COUNT, ADDR_TOP));
          issue(it);
        end
      end else if (sel < 80) begin
        issue(noise_item($urandom_range(0, 1) ? KIND_SET_ROW : KIND_SET_COL));
      end else if (sel < 86) begin
        issue(noise_item(KIND_CLEAR));
        issue(noise_item(KIND_READ));
      end else if (sel < 92) begin
        issue(noise_item(KIND_W'($urandom_range(int'(KIND_READ) + 1, KIND_TOP))));
      end else begin
        issue(noise_item(KIND_PRINT));
      end
    end
    pause(1);

    // Drain: wait for every owed item, then let the block settle
    while (shadow.pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items and checked %0d status items in %0d cycles",
             sent, shadow.checked, cycles);
    $display("Saw %0d scrolls, %0d clears and %0d reads of written cells",
             shadow.scrolls, shadow.clears, shadow.reads_hit);
    if (shadow.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors in total", shadow.errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
